### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the expression evaluator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pee_pkg.sv
// ---------------------------------------------------------------------------
// pee_pkg
// Shared constants, status codes and types of the postfix expression evaluator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

  // Width of one stack value and of the reported result.
  localparam int VALUE_WIDTH = 32;
  // Output item: value, status, zero padding up to whole bytes.
  localparam int STATUS_WIDTH = 3;
  localparam int OUT_TDATA_W  = ((VALUE_WIDTH + STATUS_WIDTH + 7) / 8) * 8;

  // Character codes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_DIVZ  = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_OVER  = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 3'd4;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Absolute value of a two's complement word, as an unsigned word.
  function automatic logic [VALUE_WIDTH-1:0] magnitude(input logic [VALUE_WIDTH-1:0] v);
    magnitude = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

### sv/pee_stack_ram.sv
// ---------------------------------------------------------------------------
// pee_stack_ram
// Operand stack storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pee_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/pee_divider.sv
// ---------------------------------------------------------------------------
// pee_divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pee_divider (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [pee_pkg::VALUE_WIDTH-1:0] dividend,
  input  wire logic [pee_pkg::VALUE_WIDTH-1:0] divisor,
  output logic      [pee_pkg::VALUE_WIDTH-1:0] quotient,
  output pee_pkg::div_stat_t                   stat
);

  import pee_pkg::*;

  localparam int CNTW = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic                   done;
  logic [CNTW-1:0]        cnt;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quot;

  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;

  // Trial subtraction of one step.
  always_comb begin
    rem_sh = {rem, quot[VALUE_WIDTH-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = (rem_sh >= {1'b0, dvs});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands are taken as magnitudes, the sign is applied at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= magnitude(divisor);
      quot <= magnitude(dividend);
      rem  <= '0;
      neg  <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
    end else if (busy) begin
      rem  <= ge ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
      quot <= {quot[VALUE_WIDTH-2:0], ge};
    end
  end

  assign quotient  = neg ? (~quot + 1'b1) : quot;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### sv/postfix_expression_evaluator.sv
// ---------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates an ASCII postfix expression with an operand stack held in RAM.
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one character per item in s_axis_tdata; tlast
//   marks the final character of an expression. Digits build a decimal
//   operand, any other character pushes it; + - * / pop two values and push
//   the result. After the last character one item is sent on the output
//   stream: a status code and the top of the stack (zero unless ok).
//   Steps per item: a digit or separator that is not last is taken in S_IDLE
//   alone, also when it pushes a pending operand. An operator checks the count
//   (S_RDB), reads two stack RAM entries (S_RDA), computes (S_EXEC), pushes
//   (S_PUSH); it stops after S_RDB on underflow, after S_EXEC on zero divisor,
//   and a division waits in S_DIV for the bit-serial divider. A last character
//   reads the top entry (S_FIN; a last digit pushes first), then waits in S_OUT.
//   The output register holds a finished item while new characters keep
//   arriving; only the final step of the next expression waits on it.
//   Reset empties the stack through its count alone (no clearing pass), and
//   clears the operand, the error status and the output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] char_code
  input  wire logic                            s_axis_tlast,  // is_last
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [pee_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [31:0] value, [34:32] status
);

  import pee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDB  = 8'b0000_0010,
    S_RDA  = 8'b0000_0100,
    S_EXEC = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_PUSH = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [VW-1:0]           accum;
  logic                    in_num;
  logic [STATUS_WIDTH-1:0] err;
  logic [7:0]              op;
  logic                    last;
  logic [VW-1:0]           b_val;
  logic [VW-1:0]           res;

  logic [VW-1:0]           accum_next;
  logic                    s_acc;
  logic                    is_digit;
  logic                    is_op;
  logic                    full;
  logic [CW-1:0]           count_m1;
  logic [CW-1:0]           count_m2;
  logic                    out_free;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [VW-1:0]           mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [VW-1:0]           mem_rdata;

  logic                    div_start;
  logic [VW-1:0]           div_q;
  div_stat_t               div_stat;

  // Input decode.
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    s_acc         = s_axis_tvalid && s_axis_tready;
    is_digit      = s_axis_tdata inside {[CH_0:CH_9]};
    is_op         = s_axis_tdata inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    accum_next    = {accum[VW-4:0], 3'b000} + {accum[VW-2:0], 1'b0}
                  + VW'(s_axis_tdata[3:0]);
    full          = (count == CW'(STACK_DEPTH));
    count_m1      = count - 1'b1;
    count_m2      = count - CW'(2);
    out_free      = !m_axis_tvalid || m_axis_tready;
  end

  // Stack RAM port control. A push lands in the RAM before any read of it.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = accum;
    mem_raddr = (state == S_RDA) ? count_m2[AW-1:0] : count_m1[AW-1:0];
    if (state == S_IDLE && s_acc && !is_digit && in_num && !full) begin
      mem_we = 1'b1;
    end
    if (state == S_PUSH && !full) begin
      mem_we    = 1'b1;
      mem_wdata = res;
    end
  end

  assign div_start = (state == S_EXEC) && (op == CH_SLASH) && (b_val != '0);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      accum         <= '0;
      in_num        <= 1'b0;
      err           <= ST_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The result register loads in S_OUT and empties on a handshake.
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            op   <= s_axis_tdata;
            last <= s_axis_tlast;
            if (is_digit) begin
              // A number still open at the last character is pushed first.
              if (s_axis_tlast) begin
                res    <= accum_next;
                accum  <= '0;
                in_num <= 1'b0;
                state  <= S_PUSH;
              end else begin
                accum  <= accum_next;
                in_num <= 1'b1;
              end
            end else begin
              if (in_num) begin
                accum  <= '0;
                in_num <= 1'b0;
                if (full) begin
                  if (err == ST_OK) begin
                    err <= ST_OVER;
                  end
                end else begin
                  count <= count + 1'b1;
                end
              end
              if (is_op) begin
                state <= S_RDB;
              end else if (s_axis_tlast) begin
                state <= S_FIN;
              end
            end
          end
        end
        S_RDB: begin
          // Fewer than two entries: the stack stays as it is.
          if (count < CW'(2)) begin
            if (err == ST_OK) begin
              err <= ST_UNDER;
            end
            state <= last ? S_FIN : S_IDLE;
          end else begin
            state <= S_RDA;
          end
        end
        S_RDA: begin
          b_val <= mem_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          count <= count_m2;
          case (op)
            CH_PLUS:  res <= mem_rdata + b_val;
            CH_MINUS: res <= mem_rdata - b_val;
            CH_STAR:  res <= mem_rdata * b_val;
            default:  res <= mem_rdata;
          endcase
          if (op == CH_SLASH) begin
            // Divide by zero leaves both operands popped and pushes nothing.
            if (b_val == '0) begin
              if (err == ST_OK) begin
                err <= ST_DIVZ;
              end
              state <= last ? S_FIN : S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end else begin
            state <= S_PUSH;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res   <= div_q;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (full) begin
            if (err == ST_OK) begin
              err <= ST_OVER;
            end
          end else begin
            count <= count + 1'b1;
          end
          state <= last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          // Top entry is being read.
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (err != ST_OK) begin
              m_axis_tdata <= {(OUT_TDATA_W - VW - STATUS_WIDTH)'(0), err, VW'(0)};
            end else if (count == '0) begin
              m_axis_tdata <= {(OUT_TDATA_W - VW - STATUS_WIDTH)'(0), ST_EMPTY, VW'(0)};
            end else begin
              m_axis_tdata <= {(OUT_TDATA_W - VW - STATUS_WIDTH)'(0), ST_OK, mem_rdata};
            end
            count  <= '0;
            accum  <= '0;
            in_num <= 1'b0;
            err    <= ST_OK;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operand stack.
  pee_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Divider; the dividend comes straight from the RAM read data.
  pee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mem_rdata),
    .divisor  (b_val),
    .quotient (div_q),
    .stat     (div_stat)
  );

endmodule

`default_nettype wire

### sv/pee_checker.sv
// ---------------------------------------------------------------------------
// pee_checker
// Port-level checks of the postfix expression evaluator, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pee_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [pee_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import pee_pkg::*;

  // After reset the block is idle with no result pending.
  `ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

  // Status is a defined code and the padding bits are zero.
  `ASSERT_CLK(a_status_code, m_axis_tvalid |-> m_axis_tdata[34:32] <= ST_EMPTY && m_axis_tdata[39:35] == 5'd0, "bad status or padding")

  // Any status other than ok carries a zero value.
  `ASSERT_CLK(a_err_zero, m_axis_tvalid && m_axis_tdata[34:32] != ST_OK |-> m_axis_tdata[31:0] == 32'd0, "nonzero value with error status")

  // A stalled result item holds.
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
